/* rtl/ble_ccc_pkg.sv */
// Types and constants shared by the client configuration table and its checker.
// Depends on nothing.
`timescale 1ns / 1ps

package ble_ccc_pkg;

  localparam int CONNECTIONS_DEF = 8;
  localparam int MAX_DESC_DEF    = 32;
  localparam int CFG_W           = 6;

  localparam logic [15:0] CCC_NOTIFY   = 16'h0001;
  localparam logic [15:0] CCC_INDICATE = 16'h0002;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_INIT  = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_QUERY = 3'd4,
    REQ_LOAD  = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_TABLE  = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_QUERY,
    S_CCC
  } state_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  conn_id;
    logic [15:0] attr_handle;
    logic [15:0] new_value;
    logic [4:0]  entry_index;
    logic [1:0]  allowed_bits;
    logic [1:0]  required_security;
    logic [1:0]  conn_security;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] read_data;
    logic        changed;
    logic [7:0]  event_conn;
    logic [4:0]  event_index;
    logic [15:0] event_handle;
    logic [15:0] event_value;
  } rsp_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [1:0]  mask;
    logic [1:0]  security;
  } desc_t;

endpackage

/* rtl/ble_ccc_table.sv */
// Client characteristic configuration table: descriptor list and per-connection words.
// Depends on ble_ccc_pkg. Init, clear, load, ignored and out-of-range query commands strobe
// done in the cycle after start; other queries read the descriptor, then the table word
// unless the security or table check fails; read and write read one descriptor per search
// step, then one table word. One command at a time; results cannot be held off.
// Synchronous reset clears table presence and settings_count; memories are not cleared.
`timescale 1ns / 1ps

module ble_ccc_table #(
  parameter int CONNECTIONS     = ble_ccc_pkg::CONNECTIONS_DEF,
  parameter int MAX_DESCRIPTORS = ble_ccc_pkg::MAX_DESC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  ble_ccc_pkg::req_t            req,
  output logic                         done,
  output ble_ccc_pkg::rsp_t            rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ble_ccc_pkg::CFG_W-1:0] cfg_data
);

  localparam int DW    = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
  localparam int CW    = $clog2(MAX_DESCRIPTORS + 1);
  localparam int PW    = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int DEPTH = CONNECTIONS * MAX_DESCRIPTORS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ble_ccc_pkg::state_t state, state_next;
  ble_ccc_pkg::req_t   req_q, cur;
  ble_ccc_pkg::rsp_t   rsp_next;

  logic [ble_ccc_pkg::CFG_W-1:0] settings_count;
  logic [CW-1:0]          active_n;
  logic [CONNECTIONS-1:0] present;
  logic [CW-1:0]          srch_idx;
  logic                   pend;
  logic [DW-1:0]          pend_idx, hit_idx;

  ble_ccc_pkg::desc_t desc_mem [MAX_DESCRIPTORS];
  ble_ccc_pkg::desc_t desc_q;
  logic               desc_re, desc_we;
  logic [DW-1:0]      desc_raddr;

  logic [15:0]   ccc_mem [DEPTH];
  logic [15:0]   ccc_q, ccc_wdata;
  logic          ccc_re, ccc_we;
  logic [AW-1:0] ccc_raddr, ccc_waddr, ccc_addr_q;

  logic          accept, fin, srch_adv, hit_take, present_set, present_clr;
  logic          conn_valid, conn_ok, hit, val_bad, idx_range;
  logic [7:0]    conn_m1;
  logic [PW-1:0] cidx;
  logic [15:0]   base, addr_full;

  assign busy      = (state != ble_ccc_pkg::S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign cur       = busy ? req_q : req;

  assign active_n = (8'(settings_count) >= 8'(MAX_DESCRIPTORS)) ?
                    CW'(MAX_DESCRIPTORS) : CW'(settings_count);

  assign conn_m1    = cur.conn_id - 8'd1;
  assign cidx       = PW'(conn_m1);
  assign conn_valid = (cur.conn_id != 8'd0) && (cur.conn_id <= 8'(CONNECTIONS));
  assign conn_ok    = conn_valid && present[cidx];
  assign idx_range  = (8'(cur.entry_index) >= 8'(active_n));

  assign base      = 16'(conn_m1) * 16'(MAX_DESCRIPTORS);
  assign addr_full = base + ((state == ble_ccc_pkg::S_SEARCH) ? 16'(pend_idx) :
                                                               16'(cur.entry_index));
  assign ccc_raddr = addr_full[AW-1:0];

  assign hit = pend && (desc_q.handle == req_q.attr_handle);
  assign val_bad = (req_q.new_value != 16'd0) &&
                   (((req_q.new_value != ble_ccc_pkg::CCC_NOTIFY) &&
                     (req_q.new_value != ble_ccc_pkg::CCC_INDICATE)) ||
                    ((req_q.new_value[1:0] & desc_q.mask) == 2'b00));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ble_ccc_pkg::S_IDLE: begin
        if (start) begin
          unique case (req.req_type) inside
            ble_ccc_pkg::REQ_READ, ble_ccc_pkg::REQ_WRITE: state_next = ble_ccc_pkg::S_SEARCH;
            ble_ccc_pkg::REQ_QUERY: begin
              if (!idx_range) state_next = ble_ccc_pkg::S_QUERY;
            end
            default: state_next = ble_ccc_pkg::S_IDLE;
          endcase
        end
      end
      ble_ccc_pkg::S_SEARCH: begin
        if (hit) begin
          if ((req_q.req_type == ble_ccc_pkg::REQ_WRITE) && val_bad) begin
            state_next = ble_ccc_pkg::S_IDLE;
          end else if (!conn_ok) begin
            state_next = ble_ccc_pkg::S_IDLE;
          end else begin
            state_next = ble_ccc_pkg::S_CCC;
          end
        end else if (srch_idx >= active_n) begin
          state_next = ble_ccc_pkg::S_IDLE;
        end
      end
      ble_ccc_pkg::S_QUERY: begin
        if ((req_q.conn_security < desc_q.security) || !conn_ok) begin
          state_next = ble_ccc_pkg::S_IDLE;
        end else begin
          state_next = ble_ccc_pkg::S_CCC;
        end
      end
      ble_ccc_pkg::S_CCC: state_next = ble_ccc_pkg::S_IDLE;
      default: state_next = ble_ccc_pkg::S_IDLE;
    endcase
  end

  // Memory controls and result
  always_comb begin
    rsp_next    = '0;
    fin         = 1'b0;
    desc_re     = 1'b0;
    desc_we     = 1'b0;
    desc_raddr  = srch_idx[DW-1:0];
    ccc_re      = 1'b0;
    ccc_we      = 1'b0;
    ccc_waddr   = ccc_addr_q;
    ccc_wdata   = cur.new_value;
    srch_adv    = 1'b0;
    hit_take    = 1'b0;
    present_set = 1'b0;
    present_clr = 1'b0;
    unique case (state)
      ble_ccc_pkg::S_IDLE: begin
        if (start) begin
          unique case (req.req_type) inside
            ble_ccc_pkg::REQ_READ, ble_ccc_pkg::REQ_WRITE: begin
              fin = 1'b0;
            end
            ble_ccc_pkg::REQ_INIT: begin
              fin = 1'b1;
              if (!conn_valid) begin
                rsp_next.status = ble_ccc_pkg::STAT_NO_TABLE;
              end else begin
                present_set = 1'b1;
                if (idx_range) begin
                  rsp_next.status = ble_ccc_pkg::STAT_RANGE;
                end else begin
                  ccc_we    = 1'b1;
                  ccc_waddr = addr_full[AW-1:0];
                  if (req.new_value != 16'd0) begin
                    rsp_next.changed     = 1'b1;
                    rsp_next.event_conn  = req.conn_id;
                    rsp_next.event_index = req.entry_index;
                    rsp_next.event_value = req.new_value;
                  end
                end
              end
            end
            ble_ccc_pkg::REQ_CLEAR: begin
              fin = 1'b1;
              if (!conn_valid) begin
                rsp_next.status = ble_ccc_pkg::STAT_NO_TABLE;
              end else begin
                present_clr = 1'b1;
              end
            end
            ble_ccc_pkg::REQ_QUERY: begin
              if (idx_range) begin
                fin             = 1'b1;
                rsp_next.status = ble_ccc_pkg::STAT_RANGE;
              end else begin
                desc_re    = 1'b1;
                desc_raddr = DW'(req.entry_index);
              end
            end
            ble_ccc_pkg::REQ_LOAD: begin
              fin = 1'b1;
              if (8'(req.entry_index) >= 8'(MAX_DESCRIPTORS)) begin
                rsp_next.status = ble_ccc_pkg::STAT_RANGE;
              end else begin
                desc_we = 1'b1;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ble_ccc_pkg::S_SEARCH: begin
        if (hit) begin
          if ((req_q.req_type == ble_ccc_pkg::REQ_WRITE) && val_bad) begin
            fin             = 1'b1;
            rsp_next.status = ble_ccc_pkg::STAT_RANGE;
          end else if (!conn_ok) begin
            fin             = 1'b1;
            rsp_next.status = ble_ccc_pkg::STAT_NO_TABLE;
          end else begin
            ccc_re   = 1'b1;
            hit_take = 1'b1;
          end
        end else if (srch_idx < active_n) begin
          desc_re  = 1'b1;
          srch_adv = 1'b1;
        end else begin
          fin             = 1'b1;
          rsp_next.status = ble_ccc_pkg::STAT_NOT_FOUND;
        end
      end
      ble_ccc_pkg::S_QUERY: begin
        if (req_q.conn_security < desc_q.security) begin
          fin = 1'b1;
        end else if (!conn_ok) begin
          fin             = 1'b1;
          rsp_next.status = ble_ccc_pkg::STAT_NO_TABLE;
        end else begin
          ccc_re = 1'b1;
        end
      end
      ble_ccc_pkg::S_CCC: begin
        fin = 1'b1;
        if (req_q.req_type == ble_ccc_pkg::REQ_WRITE) begin
          ccc_we = 1'b1;
          if (ccc_q != req_q.new_value) begin
            rsp_next.changed      = 1'b1;
            rsp_next.event_conn   = req_q.conn_id;
            rsp_next.event_index  = 5'(hit_idx);
            rsp_next.event_handle = req_q.attr_handle;
            rsp_next.event_value  = req_q.new_value;
          end
        end else begin
          rsp_next.read_data = ccc_q;
        end
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ble_ccc_pkg::S_IDLE;
      done           <= 1'b0;
      present        <= '0;
      settings_count <= '0;
      srch_idx       <= '0;
      pend           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg_valid && cfg_ready) begin
        settings_count <= cfg_data;
      end
      if (accept) begin
        srch_idx <= '0;
        pend     <= 1'b0;
      end else if (srch_adv) begin
        srch_idx <= srch_idx + CW'(1);
        pend     <= 1'b1;
      end
      if (present_set) begin
        present[cidx] <= 1'b1;
      end else if (present_clr) begin
        present[cidx] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (fin) begin
      rsp <= rsp_next;
    end
    if (srch_adv) begin
      pend_idx <= srch_idx[DW-1:0];
    end
    if (hit_take) begin
      hit_idx <= pend_idx;
    end
    if (ccc_re) begin
      ccc_addr_q <= ccc_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[DW'(req.entry_index)] <= '{handle:   req.attr_handle,
                                          mask:     req.allowed_bits,
                                          security: req.required_security};
    end
    if (desc_re) begin
      desc_q <= desc_mem[desc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ccc_we) begin
      ccc_mem[ccc_waddr] <= ccc_wdata;
    end
    if (ccc_re) begin
      ccc_q <= ccc_mem[ccc_raddr];
    end
  end

endmodule

/* rtl/ble_ccc_chk.sv */
// Port-level checks on the client configuration table, bound to its top level.
// Depends on ble_ccc_pkg and ble_ccc_table.
`timescale 1ns / 1ps

module ble_ccc_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input ble_ccc_pkg::rsp_t rsp
);

  // A result only follows an accepted transaction or work in progress
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transaction");

  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a transaction");

  // Drop busy only together with a result
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("work ended without a result");

  a_event_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.changed || (rsp.read_data != 16'd0))) |->
      (rsp.status == ble_ccc_pkg::STAT_OK))
    else $error("event or data with a failing status");

endmodule

bind ble_ccc_table ble_ccc_chk u_ble_ccc_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
